FILE: design/ced_pkg.sv
// ----------------------------------------------------------------------------
// ced_pkg: shared types, constants and helpers of the edge detector
// Holds the token that travels from the classifier to the pipeline, the
// effective configuration bundle and the ring-buffer addressing helpers.
// ----------------------------------------------------------------------------
package ced_pkg;

  localparam int MaxWidth  = 1024;
  localparam int MaxHeight = 1024;
  localparam int MinSize   = 3;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RowW      = $clog2(MaxHeight) + 1;
  localparam int AddrW     = ColW + 2;
  localparam int MemDepth  = 3 * MaxWidth;
  localparam int TanLow    = 53;
  localparam int TanHigh   = 309;
  localparam int PAddrW    = 4;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LOW    = 2'd2,
    REG_HIGH   = 2'd3
  } ced_reg_e;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } ced_op_e;

  typedef enum logic [1:0] {
    DIR_HORZ = 2'd0,
    DIR_RISE = 2'd1,
    DIR_VERT = 2'd2,
    DIR_FALL = 2'd3
  } ced_dir_e;

  typedef struct packed {
    logic [ColW-1:0] wm1;       // effective width minus one
    logic [RowW-1:0] height;    // effective height
    logic [7:0]      low_thr;
    logic [7:0]      high_thr;
  } ced_cfg_t;

  typedef struct packed {
    logic            has_pix;
    logic [7:0]      pix;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic [1:0]      bank;      // row mod 3
    logic            emit;
    logic            last;
  } ced_token_t;

  function automatic logic [1:0] bank_inc(input logic [1:0] b);
    return (b == 2'd2) ? 2'd0 : b + 2'd1;
  endfunction

  function automatic logic [1:0] bank_dec(input logic [1:0] b);
    return (b == 2'd0) ? 2'd2 : b - 2'd1;
  endfunction

  function automatic logic [AddrW-1:0] mem_addr(input logic [1:0] b,
                                                input logic [ColW-1:0] c);
    return {b, c};
  endfunction

endpackage

FILE: design/ced_cfg.sv
// ----------------------------------------------------------------------------
// ced_cfg: configuration registers
// APB-style register file; clamps the frame size and flags a frame restart.
// ----------------------------------------------------------------------------
module ced_cfg import ced_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output ced_cfg_t          cfg_o,
  output logic              restart_o
);

  logic [10:0] width_q, width_d;
  logic [10:0] height_q, height_d;
  logic [7:0]  low_q, low_d;
  logic [7:0]  high_q, high_d;
  logic        wr;
  ced_reg_e    idx;
  logic [10:0] eff_w;
  logic [10:0] eff_h;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = ced_reg_e'(paddr[PAddrW-1:2]);

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    low_d    = low_q;
    high_d   = high_q;
    if (wr) begin
      unique case (idx)
        REG_WIDTH:  width_d  = pwdata[10:0];
        REG_HEIGHT: height_d = pwdata[10:0];
        REG_LOW:    low_d    = pwdata[7:0];
        REG_HIGH:   high_d   = pwdata[7:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 11'd480;
      low_q    <= 8'd180;
      high_q   <= 8'd200;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      low_q    <= low_d;
      high_q   <= high_d;
    end
  end

  assign restart_o = wr && ((idx == REG_WIDTH) || (idx == REG_HEIGHT));

  always_comb begin
    unique case (idx)
      REG_WIDTH:  prdata = {21'd0, width_q};
      REG_HEIGHT: prdata = {21'd0, height_q};
      REG_LOW:    prdata = {24'd0, low_q};
      REG_HIGH:   prdata = {24'd0, high_q};
      default:    prdata = 32'd0;
    endcase
  end

  always_comb begin
    if (width_q < 11'(MinSize))       eff_w = 11'(MinSize);
    else if (width_q > 11'(MaxWidth)) eff_w = 11'(MaxWidth);
    else                              eff_w = width_q;
    if (height_q < 11'(MinSize))        eff_h = 11'(MinSize);
    else if (height_q > 11'(MaxHeight)) eff_h = 11'(MaxHeight);
    else                                eff_h = height_q;
  end

  assign cfg_o.wm1      = ColW'(eff_w - 11'd1);
  assign cfg_o.height   = RowW'(eff_h);
  assign cfg_o.low_thr  = low_q;
  assign cfg_o.high_thr = high_q;

endmodule

FILE: design/ced_front.sv
// ----------------------------------------------------------------------------
// ced_front: input classifier
// Tracks the raster position of the stream, turns pixel and drain words into
// pipeline tokens and decides which token produces a result.
// ----------------------------------------------------------------------------
module ced_front import ced_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ced_cfg_t   cfg_i,
  input  logic       restart_i,
  input  logic       in_valid_i,
  input  logic       in_opcode_i,
  input  logic [7:0] in_pixel_value_i,
  output logic       in_stall_o,
  input  logic       fifo_full_i,
  output logic       push_o,
  output ced_token_t token_o
);

  logic [RowW-1:0] row_q, row_d;
  logic [ColW-1:0] col_q, col_d;
  logic [1:0]      bank_q, bank_d;
  logic [RowW-1:0] row_n;
  logic [ColW-1:0] col_n;
  logic [1:0]      bank_n;
  logic [RowW-1:0] h3;
  logic            is_pix;
  logic            in_frame;
  logic            past_end;
  logic            drain_live;
  logic            need_push;
  logic            emit_n;

  assign is_pix   = (ced_op_e'(in_opcode_i) == OP_PIXEL);
  assign h3       = cfg_i.height + RowW'(3);
  assign in_frame = (row_q < cfg_i.height);
  assign past_end = (row_q > h3) || ((row_q == h3) && (col_q >= ColW'(2)));
  assign drain_live = !in_frame && !past_end;

  // restart the raster on a pixel that follows a complete frame
  always_comb begin
    if (is_pix && !in_frame) begin
      row_n  = '0;
      col_n  = '0;
      bank_n = '0;
    end else begin
      row_n  = row_q;
      col_n  = col_q;
      bank_n = bank_q;
    end
  end

  assign emit_n = ((row_n > RowW'(3)) || ((row_n == RowW'(3)) && (col_n >= ColW'(2)))) &&
                  ((row_n < h3) || ((row_n == h3) && (col_n < ColW'(2))));

  assign need_push  = is_pix || drain_live;
  assign in_stall_o = need_push && (fifo_full_i || (!is_pix && !emit_n));
  assign push_o     = in_valid_i && need_push && !fifo_full_i;

  always_comb begin
    token_o.has_pix = is_pix;
    token_o.pix     = in_pixel_value_i;
    token_o.row     = row_n;
    token_o.col     = col_n;
    token_o.bank    = bank_n;
    token_o.emit    = emit_n;
    token_o.last    = (row_n == h3) && (col_n == ColW'(1));
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    bank_d = bank_q;
    if (restart_i) begin
      row_d  = '0;
      col_d  = '0;
      bank_d = '0;
    end else if (push_o) begin
      if (col_n == cfg_i.wm1) begin
        row_d  = row_n + RowW'(1);
        col_d  = '0;
        bank_d = bank_inc(bank_n);
      end else begin
        row_d  = row_n;
        col_d  = col_n + ColW'(1);
        bank_d = bank_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      bank_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      bank_q <= bank_d;
    end
  end

endmodule

FILE: design/ced_fifo.sv
// ----------------------------------------------------------------------------
// ced_fifo: token queue
// Four-entry queue between the classifier and the pixel pipeline.
// ----------------------------------------------------------------------------
module ced_fifo import ced_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  ced_token_t wdata_i,
  input  logic       pop_i,
  output ced_token_t rdata_o,
  output logic       full_o,
  output logic       empty_o
);

  localparam int Depth = 4;
  localparam int PtrW  = $clog2(Depth);

  ced_token_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;

  assign full_o  = (count_q == (PtrW+1)'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: design/ced_back.sv
// ----------------------------------------------------------------------------
// ced_back: pixel pipeline
// Gradient, direction, non-maximum suppression and double threshold over
// three-row ring buffers, one token per cycle, stalled only by the output.
// ----------------------------------------------------------------------------
module ced_back import ced_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  ced_cfg_t   cfg_i,
  input  logic       fifo_empty_i,
  input  ced_token_t fifo_token_i,
  output logic       fifo_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_edge_value_o,
  output logic       out_frame_last_o
);

  logic [7:0] pix_mem [MemDepth];
  logic [9:0] mag_mem [MemDepth];   // {direction, magnitude}
  logic [7:0] sup_mem [MemDepth];

  logic adv;
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, out_v_q;
  logic s5_emit_q;
  logic [RowW-1:0] hm1;

  assign adv        = !out_v_q || !out_stall_i;
  assign fifo_pop_o = adv && !fifo_empty_i;
  assign hm1        = cfg_i.height - RowW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      s5_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= fifo_pop_o;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      s5_v_q  <= s4_v_q;
      out_v_q <= s5_v_q && s5_emit_q;
    end
  end

  // ---- entry: store pixel, fetch (r-1, c+1) and (r-2, c) ----
  ced_token_t       tok;
  logic [AddrW-1:0] pix_wa, pix_ra, pix_rb;
  ced_token_t       s1_tok_q;
  logic [7:0]       s1_mid_q, s1_top_q;

  assign tok    = fifo_token_i;
  assign pix_wa = mem_addr(tok.bank, tok.col);
  // at the row end fetch column 0 of this row for the next row's left tap
  assign pix_ra = (tok.col == cfg_i.wm1) ? mem_addr(tok.bank, '0)
                                         : mem_addr(bank_dec(tok.bank), tok.col + ColW'(1));
  assign pix_rb = mem_addr(bank_dec(bank_dec(tok.bank)), tok.col);

  always_ff @(posedge clk_i) begin
    if (fifo_pop_o) begin
      if (tok.has_pix) begin
        pix_mem[pix_wa] <= tok.pix;
      end
      s1_mid_q <= pix_mem[pix_ra];
      s1_top_q <= pix_mem[pix_rb];
      s1_tok_q <= tok;
    end
  end

  // ---- stage 1: central differences for (r-1, c) ----
  logic [7:0] mid1_q, mid2_q;
  logic [7:0] g_l, g_r, g_u, g_d;
  logic       xneg, yneg;
  ced_token_t s2_tok_q;
  logic [7:0] s2_gx_q, s2_gy_q;
  logic       s2_xneg_q, s2_yneg_q;

  assign g_r  = s1_mid_q;
  assign g_l  = mid2_q;
  assign g_u  = s1_top_q;
  assign g_d  = s1_tok_q.pix;
  assign xneg = g_l > g_r;
  assign yneg = g_u > g_d;

  always_ff @(posedge clk_i) begin
    if (adv && s1_v_q) begin
      mid1_q    <= s1_mid_q;
      mid2_q    <= mid1_q;
      s2_tok_q  <= s1_tok_q;
      s2_gx_q   <= xneg ? g_l - g_r : g_r - g_l;
      s2_gy_q   <= yneg ? g_u - g_d : g_d - g_u;
      s2_xneg_q <= xneg;
      s2_yneg_q <= yneg;
    end
  end

  // ---- stage 2: magnitude and direction, store, fetch rows r-2 and r-3 ----
  logic [8:0]       sum9;
  logic [16:0]      gy128, gx_lo, gx_hi;
  logic [7:0]       mag;
  ced_dir_e         dir;
  logic             m_in, m_border;
  logic [AddrW-1:0] mag_wa, mag_ra, mag_rb;
  ced_token_t       s3_tok_q;
  logic [9:0]       s3_new_q, s3_mid_q, s3_top_q;

  assign sum9  = {1'b0, s2_gx_q} + {1'b0, s2_gy_q};
  assign gy128 = {2'b00, s2_gy_q, 7'd0};
  assign gx_lo = 17'(s2_gx_q) * 17'(TanLow);
  assign gx_hi = 17'(s2_gx_q) * 17'(TanHigh);
  assign m_in  = (s2_tok_q.row >= RowW'(1)) && (s2_tok_q.row <= cfg_i.height);
  assign m_border = (s2_tok_q.row == RowW'(1)) || (s2_tok_q.row >= cfg_i.height) ||
                    (s2_tok_q.col == '0) || (s2_tok_q.col == cfg_i.wm1);

  always_comb begin
    if (m_border) begin
      mag = 8'd0;
      dir = DIR_HORZ;
    end else begin
      mag = sum9[8] ? 8'hFF : sum9[7:0];
      priority if (gy128 <= gx_lo) dir = DIR_HORZ;
      else if (gy128 > gx_hi)      dir = DIR_VERT;
      else if (s2_xneg_q != s2_yneg_q) dir = DIR_FALL;
      else                         dir = DIR_RISE;
    end
  end

  assign mag_wa = mem_addr(bank_dec(s2_tok_q.bank), s2_tok_q.col);
  assign mag_ra = mem_addr(bank_dec(bank_dec(s2_tok_q.bank)), s2_tok_q.col);
  assign mag_rb = mem_addr(s2_tok_q.bank, s2_tok_q.col);

  always_ff @(posedge clk_i) begin
    if (adv && s2_v_q) begin
      if (m_in) begin
        mag_mem[mag_wa] <= {dir, mag};
      end
      s3_mid_q <= mag_mem[mag_ra];
      s3_top_q <= mag_mem[mag_rb];
      s3_new_q <= {dir, mag};
      s3_tok_q <= s2_tok_q;
    end
  end

  // ---- stage 3: non-maximum suppression, window centered one column back ----
  logic [7:0]      t0, t1_q, t2_q, m0, m1_q, m2_q, b0, b1_q, b2_q;
  ced_dir_e        d1_q;
  logic [7:0]      na, nb, sup;
  logic [RowW-1:0] rs;
  logic [ColW-1:0] cs;
  logic            s_in, s_border;
  logic [1:0]      sbank;
  logic [RowW-1:0] s4_rs_q;
  logic [ColW-1:0] s4_cs_q;
  logic [1:0]      s4_bank_q;
  logic            s4_in_q, s4_emit_q, s4_last_q;
  logic [7:0]      s4_sup_q;

  assign t0 = s3_top_q[7:0];
  assign m0 = s3_mid_q[7:0];
  assign b0 = s3_new_q[7:0];

  always_comb begin
    if (s3_tok_q.col == '0) begin
      rs    = s3_tok_q.row - RowW'(3);
      cs    = cfg_i.wm1;
      sbank = s3_tok_q.bank;
      s_in  = (s3_tok_q.row >= RowW'(3)) && (s3_tok_q.row < cfg_i.height + RowW'(3));
    end else begin
      rs    = s3_tok_q.row - RowW'(2);
      cs    = s3_tok_q.col - ColW'(1);
      sbank = bank_dec(bank_dec(s3_tok_q.bank));
      s_in  = (s3_tok_q.row >= RowW'(2)) && (s3_tok_q.row < cfg_i.height + RowW'(2));
    end
  end

  assign s_border = (rs == '0) || (rs >= hm1) || (cs == '0) || (cs == cfg_i.wm1);

  always_comb begin
    unique case (d1_q)
      DIR_HORZ: begin na = m2_q; nb = m0;   end
      DIR_RISE: begin na = b2_q; nb = t0;   end
      DIR_VERT: begin na = t1_q; nb = b1_q; end
      DIR_FALL: begin na = t2_q; nb = b0;   end
      default:  begin na = m2_q; nb = m0;   end
    endcase
    sup = (!s_border && (na <= m1_q) && (m1_q >= nb)) ? m1_q : 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (adv && s3_v_q) begin
      t1_q      <= t0;
      t2_q      <= t1_q;
      m1_q      <= m0;
      m2_q      <= m1_q;
      b1_q      <= b0;
      b2_q      <= b1_q;
      d1_q      <= ced_dir_e'(s3_mid_q[9:8]);
      s4_rs_q   <= rs;
      s4_cs_q   <= cs;
      s4_bank_q <= sbank;
      s4_in_q   <= s_in;
      s4_sup_q  <= sup;
      s4_emit_q <= s3_tok_q.emit;
      s4_last_q <= s3_tok_q.last;
    end
  end

  // ---- stage 4: store suppressed value, fetch rows rs-1 and rs-2 ----
  logic [AddrW-1:0] sup_wa, sup_ra, sup_rb;
  logic [RowW-1:0]  s5_rs_q;
  logic [ColW-1:0]  s5_cs_q;
  logic [7:0]       s5_new_q, s5_mid_q, s5_top_q;
  logic             s5_last_q;

  assign sup_wa = mem_addr(s4_bank_q, s4_cs_q);
  assign sup_ra = mem_addr(bank_dec(s4_bank_q), s4_cs_q);
  assign sup_rb = mem_addr(bank_dec(bank_dec(s4_bank_q)), s4_cs_q);

  always_ff @(posedge clk_i) begin
    if (adv && s4_v_q) begin
      if (s4_in_q) begin
        sup_mem[sup_wa] <= s4_sup_q;
      end
      s5_mid_q  <= sup_mem[sup_ra];
      s5_top_q  <= sup_mem[sup_rb];
      s5_new_q  <= s4_sup_q;
      s5_rs_q   <= s4_rs_q;
      s5_cs_q   <= s4_cs_q;
      s5_emit_q <= s4_emit_q;
      s5_last_q <= s4_last_q;
    end
  end

  // ---- stage 5: double threshold with neighbor check ----
  logic [7:0]      u1_q, u2_q, v1_q, v2_q, w1_q, w2_q;
  logic [7:0]      ctr, any_nb, edge_val;
  logic [RowW-1:0] rp;
  logic [ColW-1:0] cp;
  logic            p_border;

  assign ctr    = v1_q;
  assign any_nb = s5_top_q | u1_q | u2_q | s5_mid_q | v2_q | s5_new_q | w1_q | w2_q;
  assign rp     = s5_rs_q - RowW'(1);
  assign cp     = s5_cs_q - ColW'(1);
  // a window that wraps the row edge always sits on a border column
  assign p_border = (s5_cs_q == '0) || (rp == '0) || (rp >= hm1) ||
                    (cp == '0) || (cp == cfg_i.wm1);

  always_comb begin
    priority if (p_border)             edge_val = 8'd0;
    else if (ctr < cfg_i.low_thr)      edge_val = 8'd0;
    else if (ctr >= cfg_i.high_thr)    edge_val = ctr;
    else if (any_nb != 8'd0)           edge_val = ctr;
    else                               edge_val = 8'd0;
  end

  always_ff @(posedge clk_i) begin
    if (adv && s5_v_q) begin
      u1_q             <= s5_top_q;
      u2_q             <= u1_q;
      v1_q             <= s5_mid_q;
      v2_q             <= v1_q;
      w1_q             <= s5_new_q;
      w2_q             <= w1_q;
      out_edge_value_o <= edge_val;
      out_frame_last_o <= s5_last_q;
    end
  end

  assign out_valid_o = out_v_q;

endmodule

FILE: design/canny_edge_detector_core.sv
// A result word is registered through the token queue and each pipeline stage.
// Throughput: one word per cycle while the token queue is not full; a drain word
// that starts the tail of a three-row frame holds the input while the raster
// position walks ahead. The pipeline holds only when the output word is stalled.
// Reset: raster position cleared, registers to 640 / 480 / 180 / 200; the
// three-row line memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// canny_edge_detector_core: streaming 3x3 edge detector
// Classifier and token queue in front of a line-buffer pipeline.
// ----------------------------------------------------------------------------
module canny_edge_detector_core import ced_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              in_opcode_i,
  input  logic [7:0]        in_pixel_value_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        out_edge_value_o,
  output logic              out_frame_last_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PAddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  ced_cfg_t   cfg;
  logic       restart;
  logic       fifo_push, fifo_pop, fifo_full, fifo_empty;
  ced_token_t push_tok, head_tok;

  ced_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  ced_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .restart_i        (restart),
    .in_valid_i       (in_valid_i),
    .in_opcode_i      (in_opcode_i),
    .in_pixel_value_i (in_pixel_value_i),
    .in_stall_o       (in_stall_o),
    .fifo_full_i      (fifo_full),
    .push_o           (fifo_push),
    .token_o          (push_tok)
  );

  ced_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .wdata_i (push_tok),
    .pop_i   (fifo_pop),
    .rdata_o (head_tok),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  ced_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .fifo_empty_i     (fifo_empty),
    .fifo_token_i     (head_tok),
    .fifo_pop_o       (fifo_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_edge_value_o (out_edge_value_o),
    .out_frame_last_o (out_frame_last_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("token queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("token queue underflow");

  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_frame_last_o) |-> (out_edge_value_o == 8'd0))
    else $error("last pixel of a frame is a border pixel and must be zero");

endmodule
